FILE: rtl/core/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion converter.
`timescale 1ns / 1ps

package rmq_pkg;

    // Which of the four Shepperd branches produced a result.
    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int THR_W  = 31;
    localparam logic [APB_AW-1:0] ADDR_TRACE_THR = 3'd0;

endpackage

FILE: rtl/core/rotation_matrix_to_quaternion.sv
// Top level of the rotation matrix to quaternion converter (Shepperd's method).
// The pipeline runs through the capture, trace and branch-selection stages, then
// RW = (DATA_WIDTH + 3 + FRAC_BITS) / 2 square-root stages and NW = DATA_WIDTH + 1 + FRAC_BITS
// divider stages, then the output register.
// Throughput: one item per cycle; the pipeline halts only when the output skid register is full.
// Reset clears all valid bits, including the skid and output valid flags, and thr_reg (to zero).
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 30
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // APB-style configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rmq_pkg::APB_AW-1:0]             paddr,
    input  logic [rmq_pkg::APB_DW-1:0]             pwdata,
    output logic [rmq_pkg::APB_DW-1:0]             prdata,
    output logic                                   pready,
    // Input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, lowest bits first: m00, m01, m02, m10, m11, m12, m20, m21, m22
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // Output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata, lowest bits first: quat_x, quat_y, quat_z, quat_w
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    // tuser, lowest bits first: branch_taken (2 bits), invalid (1 bit)
    output logic [2:0]                             m_axis_tuser
);

    import rmq_pkg::*;

    localparam int DW     = DATA_WIDTH;
    localparam int FB     = FRAC_BITS;
    localparam int SDW    = ((9*DW+7)/8)*8;
    localparam int MDW    = ((4*DW+7)/8)*8;
    localparam int TW     = DW + 2;                 // trace width
    localparam int CW     = (TW >= 32) ? TW : 32;   // trace compare width
    localparam int AW     = DW + 3;                 // signed sqrt argument
    localparam int UW     = DW + 2;                 // positive argument magnitude
    localparam int RW     = (UW + FB + 1) / 2;      // root width
    localparam int NMW    = DW + 1;                 // numerator width
    localparam int NW     = NMW + FB;               // quotient width
    localparam int DENW   = RW + 1;
    localparam int SQTAGW = 3 + 3*NMW;
    localparam int XW     = ((NW > RW) ? NW : RW) + 1;
    localparam logic [AW-1:0] ONE_A     = AW'(1) << FB;
    localparam logic [XW-1:0] LIM_POS   = (XW'(1) << (DW-1)) - XW'(1);
    localparam logic [XW-1:0] LIM_NEG   = XW'(1) << (DW-1);
    localparam logic [DW-1:0] SAT_HI    = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SAT_LO    = {1'b1, {(DW-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration register. Only the trace threshold exists; writes to
    // any other address are dropped.
    // ------------------------------------------------------------------
    logic [THR_W-1:0] thr_reg;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TRACE_THR) ? APB_DW'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_wr && (paddr == ADDR_TRACE_THR))
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable. The whole pipe advances together and only holds
    // when the skid register already carries a result nobody has taken.
    // ------------------------------------------------------------------
    logic en;
    logic ov_reg;
    logic sv_reg;

    assign en            = !sv_reg;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: capture the matrix.
    // ------------------------------------------------------------------
    logic                 v1_reg;
    logic signed [DW-1:0] m1_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                m1_reg[i] <= s_axis_tdata[i*DW +: DW];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: trace, diagonal comparisons and the six off-diagonal sums
    // and differences that feed the divisions.
    // ------------------------------------------------------------------
    logic                  v2_reg;
    logic signed [TW-1:0]  t2_reg;
    logic                  c01_reg, c02_reg, c12_reg;
    logic signed [DW-1:0]  d00_reg, d11_reg, d22_reg;
    logic signed [NMW-1:0] d21_12_reg, d02_20_reg, d10_01_reg;
    logic signed [NMW-1:0] s01_10_reg, s02_20_reg, s12_21_reg;

    logic signed [TW-1:0]  t2_next;

    assign t2_next = {{2{m1_reg[0][DW-1]}}, m1_reg[0]}
                   + {{2{m1_reg[4][DW-1]}}, m1_reg[4]}
                   + {{2{m1_reg[8][DW-1]}}, m1_reg[8]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_reg     <= t2_next;
            c01_reg    <= (m1_reg[0] > m1_reg[4]);
            c02_reg    <= (m1_reg[0] > m1_reg[8]);
            c12_reg    <= (m1_reg[4] > m1_reg[8]);
            d00_reg    <= m1_reg[0];
            d11_reg    <= m1_reg[4];
            d22_reg    <= m1_reg[8];
            d21_12_reg <= {m1_reg[7][DW-1], m1_reg[7]} - {m1_reg[5][DW-1], m1_reg[5]};
            d02_20_reg <= {m1_reg[2][DW-1], m1_reg[2]} - {m1_reg[6][DW-1], m1_reg[6]};
            d10_01_reg <= {m1_reg[3][DW-1], m1_reg[3]} - {m1_reg[1][DW-1], m1_reg[1]};
            s01_10_reg <= {m1_reg[1][DW-1], m1_reg[1]} + {m1_reg[3][DW-1], m1_reg[3]};
            s02_20_reg <= {m1_reg[2][DW-1], m1_reg[2]} + {m1_reg[6][DW-1], m1_reg[6]};
            s12_21_reg <= {m1_reg[5][DW-1], m1_reg[5]} + {m1_reg[7][DW-1], m1_reg[7]};
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: branch selection and square-root argument. On a diagonal
    // branch i the argument is ONE + 2*mii - trace. The three numerators
    // are routed so that divider k always serves the k-th non-root
    // component in x, y, z, w order.
    // ------------------------------------------------------------------
    logic                  v3_reg;
    branch_t               br3_reg;
    logic                  bad3_reg;
    logic [2*RW-1:0]       rad3_reg;
    logic signed [NMW-1:0] n3_reg [3];

    logic signed [AW-1:0]  t_a;
    logic signed [AW-1:0]  mii_a;
    logic signed [AW-1:0]  a_sel;
    logic signed [CW-1:0]  t_c;
    logic signed [CW-1:0]  thr_c;
    logic                  use_trace;
    branch_t               br3_next;
    logic                  bad3_next;
    logic signed [NMW-1:0] n3_next [3];

    assign t_a   = {{(AW-TW){t2_reg[TW-1]}}, t2_reg};
    assign t_c   = {{(CW-TW){t2_reg[TW-1]}}, t2_reg};
    assign thr_c = {{(CW-THR_W){1'b0}}, thr_reg};
    assign use_trace = (t_c > thr_c);

    always_comb
    begin
        if (use_trace)
        begin
            br3_next = BR_TRACE;
        end
        else if (c01_reg && c02_reg)
        begin
            br3_next = BR_X;
        end
        else if (c12_reg)
        begin
            br3_next = BR_Y;
        end
        else
        begin
            br3_next = BR_Z;
        end

        case (br3_next)
            BR_X:    mii_a = {{(AW-DW){d00_reg[DW-1]}}, d00_reg};
            BR_Y:    mii_a = {{(AW-DW){d11_reg[DW-1]}}, d11_reg};
            default: mii_a = {{(AW-DW){d22_reg[DW-1]}}, d22_reg};
        endcase

        if (use_trace)
        begin
            a_sel = t_a + ONE_A;
        end
        else
        begin
            a_sel = ONE_A + (mii_a <<< 1) - t_a;
        end
        bad3_next = !use_trace && (a_sel <= 0);

        case (br3_next)
            BR_TRACE:
            begin
                n3_next[0] = d21_12_reg;
                n3_next[1] = d02_20_reg;
                n3_next[2] = d10_01_reg;
            end
            BR_X:
            begin
                n3_next[0] = s01_10_reg;
                n3_next[1] = s02_20_reg;
                n3_next[2] = d21_12_reg;
            end
            BR_Y:
            begin
                n3_next[0] = s01_10_reg;
                n3_next[1] = s12_21_reg;
                n3_next[2] = d02_20_reg;
            end
            default:
            begin
                n3_next[0] = s02_20_reg;
                n3_next[1] = s12_21_reg;
                n3_next[2] = d10_01_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            br3_reg  <= br3_next;
            bad3_reg <= bad3_next;
            // A rejected argument feeds zero; its results are zeroed and flagged invalid.
            rad3_reg <= bad3_next ? '0 : (2*RW)'({a_sel[UW-1:0], {FB{1'b0}}});
            for (int i = 0; i < 3; i++)
            begin
                n3_reg[i] <= n3_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Square root: RW stages. The branch, the error flag and the three
    // numerators ride along as a tag.
    // ------------------------------------------------------------------
    logic                  sq_valid;
    logic [RW-1:0]         sq_root;
    logic [SQTAGW-1:0]     sq_tag;
    logic [1:0]            sq_br;
    logic                  sq_bad;
    logic signed [NMW-1:0] sq_n [3];

    rmq_isqrt #(
        .RW   (RW),
        .TAGW (SQTAGW)
    ) u_isqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (v3_reg),
        .in_radicand (rad3_reg),
        .in_tag      ({n3_reg[2], n3_reg[1], n3_reg[0], bad3_reg, br3_reg}),
        .out_valid   (sq_valid),
        .out_root    (sq_root),
        .out_tag     (sq_tag)
    );

    assign sq_br   = sq_tag[1:0];
    assign sq_bad  = sq_tag[2];
    assign sq_n[0] = sq_tag[3 +: NMW];
    assign sq_n[1] = sq_tag[3+NMW +: NMW];
    assign sq_n[2] = sq_tag[3+2*NMW +: NMW];

    // ------------------------------------------------------------------
    // Three dividers by 2r, NW stages each. Divider 0 carries the branch,
    // divider 1 the halved root and divider 2 the error flag.
    // ------------------------------------------------------------------
    logic              dv_valid;
    logic [NW-1:0]     dv_quot [3];
    logic              dv_neg  [3];
    logic [1:0]        dv_br;
    logic [RW-2:0]     dv_rhalf;
    logic              dv_bad;

    rmq_div #(
        .NMW (NMW), .FB (FB), .DENW (DENW), .TAGW (2)
    ) u_div0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_numer  (sq_n[0]),
        .in_den    ({sq_root, 1'b0}),
        .in_tag    (sq_br),
        .out_valid (dv_valid),
        .out_quot  (dv_quot[0]),
        .out_neg   (dv_neg[0]),
        .out_tag   (dv_br)
    );

    rmq_div #(
        .NMW (NMW), .FB (FB), .DENW (DENW), .TAGW (RW-1)
    ) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_numer  (sq_n[1]),
        .in_den    ({sq_root, 1'b0}),
        .in_tag    (sq_root[RW-1:1]),
        .out_valid (),
        .out_quot  (dv_quot[1]),
        .out_neg   (dv_neg[1]),
        .out_tag   (dv_rhalf)
    );

    rmq_div #(
        .NMW (NMW), .FB (FB), .DENW (DENW), .TAGW (1)
    ) u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_numer  (sq_n[2]),
        .in_den    ({sq_root, 1'b0}),
        .in_tag    (sq_bad),
        .out_valid (),
        .out_quot  (dv_quot[2]),
        .out_neg   (dv_neg[2]),
        .out_tag   (dv_bad)
    );

    // ------------------------------------------------------------------
    // Sign, saturation and placement. Component 3 is the halved root,
    // which is never negative. A rejected argument zeroes all four components.
    // ------------------------------------------------------------------
    logic [XW-1:0] c_mag [4];
    logic          c_neg [4];
    logic [DW-1:0] c_val [4];
    logic          c_sat [4];
    logic [DW-1:0] qx, qy, qz, qw;
    logic          res_invalid;
    logic [MDW-1:0] res_data;
    logic [2:0]     res_user;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_mag[i] = XW'(dv_quot[i]);
            c_neg[i] = dv_neg[i];
        end
        c_mag[3] = XW'(dv_rhalf);
        c_neg[3] = 1'b0;

        for (int i = 0; i < 4; i++)
        begin
            if (c_neg[i])
            begin
                c_sat[i] = (c_mag[i] > LIM_NEG);
                c_val[i] = c_sat[i] ? SAT_LO : (DW'(0) - c_mag[i][DW-1:0]);
            end
            else
            begin
                c_sat[i] = (c_mag[i] > LIM_POS);
                c_val[i] = c_sat[i] ? SAT_HI : c_mag[i][DW-1:0];
            end
        end

        case (branch_t'(dv_br))
            BR_TRACE:
            begin
                qx = c_val[0]; qy = c_val[1]; qz = c_val[2]; qw = c_val[3];
            end
            BR_X:
            begin
                qx = c_val[3]; qy = c_val[0]; qz = c_val[1]; qw = c_val[2];
            end
            BR_Y:
            begin
                qx = c_val[0]; qy = c_val[3]; qz = c_val[1]; qw = c_val[2];
            end
            default:
            begin
                qx = c_val[0]; qy = c_val[1]; qz = c_val[3]; qw = c_val[2];
            end
        endcase

        if (dv_bad)
        begin
            qx = '0;
            qy = '0;
            qz = '0;
            qw = '0;
        end

        res_invalid = dv_bad || c_sat[0] || c_sat[1] || c_sat[2] || c_sat[3];
        res_data    = MDW'({qw, qz, qy, qx});
        res_user    = {res_invalid, dv_br};
    end

    // ------------------------------------------------------------------
    // Output register with a one-entry skid. While a result waits at the
    // output the pipe keeps moving until the skid entry is filled, so one
    // more item can still be accepted.
    // ------------------------------------------------------------------
    logic [MDW-1:0] out_data_reg, out_data_next;
    logic [2:0]     out_user_reg, out_user_next;
    logic [MDW-1:0] skid_data_reg, skid_data_next;
    logic [2:0]     skid_user_reg, skid_user_next;
    logic           ov_next, sv_next;

    always_comb
    begin
        ov_next        = ov_reg;
        sv_next        = sv_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        skid_data_next = skid_data_reg;
        skid_user_next = skid_user_reg;

        if (ov_reg && !m_axis_tready)
        begin
            if (en && dv_valid)
            begin
                sv_next        = 1'b1;
                skid_data_next = res_data;
                skid_user_next = res_user;
            end
        end
        else if (sv_reg)
        begin
            ov_next       = 1'b1;
            sv_next       = 1'b0;
            out_data_next = skid_data_reg;
            out_user_next = skid_user_reg;
        end
        else
        begin
            ov_next       = dv_valid;
            out_data_next = res_data;
            out_user_next = res_user;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            sv_reg <= sv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        skid_data_reg <= skid_data_next;
        skid_user_reg <= skid_user_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The skid entry is only ever filled behind a waiting output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        sv_reg |-> ov_reg)
        else $error("skid entry holds data while the output register is empty");

    // A taken output with a full skid must be refilled from the skid.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && m_axis_tready && sv_reg) |=> (ov_reg && !sv_reg))
        else $error("skid entry was not moved to the output");

    // On the trace path w is half a square root and can never be negative.
    a_trace_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[1:0] == BR_TRACE))
            |-> !m_axis_tdata[4*DW-1])
        else $error("negative w on the trace path");

endmodule

FILE: rtl/core/rmq_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module rmq_isqrt #(
    parameter int RW   = 32,
    parameter int TAGW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   in_radicand,
    input  logic [TAGW-1:0]   in_tag,
    output logic              out_valid,
    output logic [RW-1:0]     out_root,
    output logic [TAGW-1:0]   out_tag
);

    logic              vld_reg  [RW];
    logic [RW+1:0]     rem_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [2*RW-1:0]   rad_reg  [RW];
    logic [TAGW-1:0]   tag_reg  [RW];

    generate
        for (genvar k = 0; k < RW; k++)
        begin : g_stage
            logic              src_vld;
            logic [RW+1:0]     src_rem;
            logic [RW-1:0]     src_root;
            logic [2*RW-1:0]   src_rad;
            logic [TAGW-1:0]   src_tag;
            logic [RW+3:0]     trial;
            logic [RW+3:0]     sub;
            logic              fit;
            logic [RW+1:0]     rem_next;
            logic [RW-1:0]     root_next;

            if (k == 0)
            begin : g_first
                assign src_vld  = in_valid;
                assign src_rem  = '0;
                assign src_root = '0;
                assign src_rad  = in_radicand;
                assign src_tag  = in_tag;
            end
            else
            begin : g_next
                assign src_vld  = vld_reg[k-1];
                assign src_rem  = rem_reg[k-1];
                assign src_root = root_reg[k-1];
                assign src_rad  = rad_reg[k-1];
                assign src_tag  = tag_reg[k-1];
            end

            // Bring down the next two radicand bits and try root*4+1.
            assign trial     = {src_rem, src_rad[2*RW-1 -: 2]};
            assign sub       = (RW+4)'({src_root, 2'b01});
            assign fit       = (trial >= sub);
            assign rem_next  = fit ? (RW+2)'(trial - sub) : trial[RW+1:0];
            assign root_next = {src_root[RW-2:0], fit};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= src_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    rad_reg[k]  <= src_rad << 2;
                    tag_reg[k]  <= src_tag;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_tag   = tag_reg[RW-1];

endmodule

FILE: rtl/core/rmq_div.sv
// Pipelined restoring divider for (|n| << FB) / den, one quotient bit per stage.
`timescale 1ns / 1ps

module rmq_div #(
    parameter int NMW  = 33,
    parameter int FB   = 30,
    parameter int DENW = 33,
    parameter int TAGW = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [NMW-1:0]  in_numer,
    input  logic [DENW-1:0]        in_den,
    input  logic [TAGW-1:0]        in_tag,
    output logic                   out_valid,
    output logic [NMW+FB-1:0]      out_quot,
    output logic                   out_neg,
    output logic [TAGW-1:0]        out_tag
);

    localparam int NW = NMW + FB;

    logic              vld_reg  [NW];
    logic [DENW-1:0]   rem_reg  [NW];
    logic [NW-1:0]     dvd_reg  [NW];
    logic [NW-1:0]     quot_reg [NW];
    logic [DENW-1:0]   den_reg  [NW];
    logic              neg_reg  [NW];
    logic [TAGW-1:0]   tag_reg  [NW];

    logic              in_neg;
    logic [NMW-1:0]    in_mag;

    assign in_neg = in_numer[NMW-1];
    assign in_mag = in_neg ? (NMW'(0) - NMW'(in_numer)) : NMW'(in_numer);

    generate
        for (genvar k = 0; k < NW; k++)
        begin : g_stage
            logic              src_vld;
            logic [DENW-1:0]   src_rem;
            logic [NW-1:0]     src_dvd;
            logic [NW-1:0]     src_quot;
            logic [DENW-1:0]   src_den;
            logic              src_neg;
            logic [TAGW-1:0]   src_tag;
            logic [DENW:0]     trial;
            logic              fit;
            logic [DENW-1:0]   rem_next;

            if (k == 0)
            begin : g_first
                assign src_vld  = in_valid;
                assign src_rem  = '0;
                assign src_dvd  = {in_mag, {FB{1'b0}}};
                assign src_quot = '0;
                assign src_den  = in_den;
                assign src_neg  = in_neg;
                assign src_tag  = in_tag;
            end
            else
            begin : g_next
                assign src_vld  = vld_reg[k-1];
                assign src_rem  = rem_reg[k-1];
                assign src_dvd  = dvd_reg[k-1];
                assign src_quot = quot_reg[k-1];
                assign src_den  = den_reg[k-1];
                assign src_neg  = neg_reg[k-1];
                assign src_tag  = tag_reg[k-1];
            end

            assign trial    = {src_rem, src_dvd[NW-1]};
            assign fit      = (trial >= {1'b0, src_den});
            assign rem_next = fit ? DENW'(trial - {1'b0, src_den}) : trial[DENW-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= src_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    dvd_reg[k]  <= src_dvd << 1;
                    quot_reg[k] <= {src_quot[NW-2:0], fit};
                    den_reg[k]  <= src_den;
                    neg_reg[k]  <= src_neg;
                    tag_reg[k]  <= src_tag;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NW-1];
    assign out_quot  = quot_reg[NW-1];
    assign out_neg   = neg_reg[NW-1];
    assign out_tag   = tag_reg[NW-1];

endmodule
